/* rtl/vld_pkg.sv */
`timescale 1ns / 1ps
package vld_pkg;

  localparam int CFG_W = 13;
  localparam int ROW_W = 12;
  localparam int COL_W = 12;
  localparam int BYTE_W = 8;
  localparam int IDX_W = 4;

  localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 4'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
  } vld_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [BYTE_W-1:0] pixel;
    logic              frame_end;
  } vld_out_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } vld_cfg_t;

  // Contents of the input register as seen by the parser.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] byte_in;
  } vld_stage_t;

  typedef struct packed {
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] frame_height;
  } vld_regs_t;

endpackage

/* rtl/vld_stream_if.sv */
`timescale 1ns / 1ps
interface vld_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/vld_cfg_regs.sv */
`timescale 1ns / 1ps
module vld_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  vld_stream_if.sink        cfg,
  output vld_pkg::vld_regs_t regs
);
  import vld_pkg::*;

  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] frame_height;

  // Writes are always taken; an index outside the register list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        REG_LINE_WIDTH: line_width <= cfg.payload.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  assign regs.line_width = line_width;
  assign regs.frame_height = frame_height;
endmodule

/* rtl/vld_in_reg.sv */
`timescale 1ns / 1ps
module vld_in_reg (
  input  logic                clk,
  input  logic                rst,
  vld_stream_if.sink          stream,
  input  logic                advance,
  output vld_pkg::vld_stage_t held
);
  import vld_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] data;

  // The register can refill in the same cycle that the parser consumes it.
  assign stream.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      data <= stream.payload.byte_in;
    end
  end

  assign held.valid = valid;
  assign held.byte_in = data;
endmodule

/* rtl/vld_parser.sv */
`timescale 1ns / 1ps
module vld_parser #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  vld_pkg::vld_stage_t held,
  input  vld_pkg::vld_regs_t  regs,
  output logic                advance,
  vld_stream_if.source        result
);
  import vld_pkg::*;

  localparam int POS_W = $clog2(MAX_WIDTH);
  localparam int SUM_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_GOT_FIRST = 3'd1;
  localparam logic [2:0] PH_ROW_HI = 3'd2;
  localparam logic [2:0] PH_ROW_LO = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;

  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] row_high_byte, row_high_byte_next;
  logic [ROW_W-1:0]  current_row, current_row_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;

  logic              res_valid;
  vld_out_t          res, res_next;
  logic              emit;

  logic [CFG_W-1:0]  width_nz, eff_width, eff_height;
  logic [15:0]       row_num;
  logic [SUM_W-1:0]  pos_inc;
  logic              last;
  logic              final_row;

  // Saturate the registers to the supported frame geometry.
  assign width_nz = (regs.line_width == '0) ? CFG_W'(1) : regs.line_width;
  assign eff_width = (32'(width_nz) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_nz;
  assign eff_height = (32'(regs.frame_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT)
                                                            : regs.frame_height;

  assign row_num = {row_high_byte, held.byte_in};
  assign pos_inc = SUM_W'(byte_position) + SUM_W'(1);
  assign last = pos_inc >= SUM_W'(eff_width);
  assign final_row = (CFG_W'(current_row) + CFG_W'(1)) == eff_height;

  assign advance = held.valid && (!res_valid || result.ready);

  always_comb begin
    phase_next = phase;
    row_high_byte_next = row_high_byte;
    current_row_next = current_row;
    byte_position_next = byte_position;
    emit = 1'b0;
    res_next = '0;
    case (phase)
      PH_GOT_FIRST: begin
        phase_next = (held.byte_in == SYNC_SECOND) ? PH_ROW_HI : PH_HUNT;
      end
      PH_ROW_HI: begin
        row_high_byte_next = held.byte_in;
        phase_next = PH_ROW_LO;
      end
      PH_ROW_LO: begin
        if (row_num >= 16'(eff_height)) begin
          phase_next = PH_HUNT;
          emit = 1'b1;
          res_next.result_kind = KIND_REJECT;
        end else begin
          current_row_next = row_num[ROW_W-1:0];
          byte_position_next = '0;
          phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        emit = 1'b1;
        res_next.result_kind = KIND_PIXEL;
        res_next.row = current_row;
        res_next.column = COL_W'(byte_position);
        res_next.pixel = held.byte_in;
        res_next.frame_end = (pos_inc == SUM_W'(eff_width)) && final_row;
        if (last) begin
          phase_next = PH_HUNT;
          byte_position_next = '0;
        end else begin
          byte_position_next = POS_W'(pos_inc);
        end
      end
      default: begin
        phase_next = (held.byte_in == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      row_high_byte <= '0;
      current_row <= '0;
      byte_position <= '0;
    end else if (advance) begin
      phase <= phase_next;
      row_high_byte <= row_high_byte_next;
      current_row <= current_row_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.payload = res;
endmodule

/* rtl/video_line_deframer.sv */
`timescale 1ns / 1ps
// Channel  | Role   | Payload                                      | Handshake
// stream   | sink   | byte_in                                      | valid / ready
// result   | source | result_kind, row, column, pixel, frame_end   | valid / ready
// cfg      | sink   | index, data                                  | valid / ready (ready high)
//
// One byte is accepted every clock while the result side keeps up.
// A byte waits in the input register and its request, if any, is loaded
// into the result register when the parser consumes the byte, which it does
// once the result register is free; result valid rises with that load.
// Synchronous active-high reset returns the parser to the sync hunt and
// restores the register defaults of 640 pixels by 480 rows.
// A held result stalls the input side only once the input register is full too.
module video_line_deframer #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic         clk,
  input  logic         rst,
  vld_stream_if.sink   stream,
  vld_stream_if.source result,
  vld_stream_if.sink   cfg
);
  import vld_pkg::*;

  // Register file for line width and frame height. Writes are applied
  // immediately and are expected only while no bytes are in flight.
  vld_regs_t  regs;

  // Contents of the input register and the handshake that drains it.
  vld_stage_t held;
  logic       advance;

  vld_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The input register decouples the stream side from the result register,
  // so a new byte is taken in the same cycle the previous one is parsed.
  vld_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .advance (advance),
    .held    (held)
  );

  // The parser walks the sync pair, the big-endian row number and the pixel
  // bytes. Each byte is resolved in a single pass of logic that updates the
  // phase, row and column counters and loads the result register.
  vld_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .held    (held),
    .regs    (regs),
    .advance (advance),
    .result  (result)
  );
endmodule

/* rtl/vld_checker.sv */
`timescale 1ns / 1ps
module vld_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input vld_pkg::vld_out_t  out_payload
);
  import vld_pkg::*;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // A rejected line carries no row, column, pixel or frame end.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_payload.result_kind == KIND_REJECT) |->
      (out_payload.row == '0) && (out_payload.column == '0) &&
      (out_payload.pixel == '0) && !out_payload.frame_end)
    else $error("rejected line carries data fields");

  // Frame end belongs to a pixel request only.
  a_frame_end_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.frame_end |-> out_payload.result_kind == KIND_PIXEL)
    else $error("frame end on a rejected line");

  // Reset clears any pending result.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind video_line_deframer vld_checker u_vld_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_payload (result.payload)
);
